// File: rtl/core/apr_pkg.sv
`default_nettype none
package apr_pkg;

    localparam int COORD_W = 24;
    localparam int EXT_W   = 23;
    localparam int COEF_W  = 24;
    localparam int PROD_W  = 2 * COEF_W;
    // products, offset scaled by 2^COEF_FRAC_BITS and corner terms, with headroom
    localparam int ACC_W   = 52;

    typedef enum logic [2:0] {
        REG_COEF_XX  = 3'd0,
        REG_COEF_XY  = 3'd1,
        REG_OFFSET_X = 3'd2,
        REG_COEF_YX  = 3'd3,
        REG_COEF_YY  = 3'd4,
        REG_OFFSET_Y = 3'd5
    } t_reg_idx;

    localparam logic OP_POINT = 1'b0;
    localparam logic OP_RECT  = 1'b1;

    typedef struct packed {
        logic                      operation;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic        [EXT_W-1:0]   extent_w;
        logic        [EXT_W-1:0]   extent_h;
    } t_req;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic        [EXT_W-1:0]   out_w;
        logic        [EXT_W-1:0]   out_h;
        logic                      clipped;
    } t_res;

    // rounded low and high ends of one output axis
    typedef struct packed {
        logic signed [ACC_W-1:0] lo;
        logic signed [ACC_W-1:0] hi;
    } t_span;

endpackage
`default_nettype wire

// File: rtl/core/affine_point_rect_map.sv
`default_nettype none
// Maps a point, or the four corners of a rectangle to their bounding box,
// through a 2x3 fixed-point affine matrix held in six registers. One item
// per clock, every clock: busy is always low. A result appears with o_valid
// high for one cycle, after the pipeline of input register, multipliers,
// adders, rounding and saturation. The receiver cannot hold results off and
// must take each one in its strobe cycle. The user must write the registers
// only while no item is in flight; the block itself does not enforce this.
module affine_point_rect_map
    import apr_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  t_req                     i_req,
    output logic                     o_valid,
    output t_res                     o_res,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [COEF_W-1:0]   i_cfg_data
);

    localparam logic signed [COEF_W-1:0] ONE = COEF_W'(1) << COEF_FRAC_BITS;
    localparam int LAT = 5;

    logic signed [COEF_W-1:0]  r_cxx, r_cxy, r_cyx, r_cyy;
    logic signed [COORD_W-1:0] r_offx, r_offy;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic        [EXT_W-1:0]   r_w, r_h;
    logic        [LAT-1:0]     r_vld;
    logic                      accept;
    t_span                     span_x, span_y;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cxx  <= ONE;
            r_cxy  <= '0;
            r_offx <= '0;
            r_cyx  <= '0;
            r_cyy  <= ONE;
            r_offy <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COEF_XX:  r_cxx  <= i_cfg_data;
                REG_COEF_XY:  r_cxy  <= i_cfg_data;
                REG_OFFSET_X: r_offx <= i_cfg_data;
                REG_COEF_YX:  r_cyx  <= i_cfg_data;
                REG_COEF_YY:  r_cyy  <= i_cfg_data;
                REG_OFFSET_Y: r_offy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], accept};
        end
    end

    // a point is a rectangle of zero size
    always_ff @(posedge i_clk) begin
        r_x <= i_req.pos_x;
        r_y <= i_req.pos_y;
        r_w <= (i_req.operation == OP_RECT) ? i_req.extent_w : '0;
        r_h <= (i_req.operation == OP_RECT) ? i_req.extent_h : '0;
    end

    apr_axis #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_axis_x (
        .i_clk  (i_clk),
        .i_ca   (r_cxx),
        .i_cb   (r_cxy),
        .i_off  (r_offx),
        .i_x    (r_x),
        .i_y    (r_y),
        .i_w    (r_w),
        .i_h    (r_h),
        .o_span (span_x)
    );

    apr_axis #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_axis_y (
        .i_clk  (i_clk),
        .i_ca   (r_cyx),
        .i_cb   (r_cyy),
        .i_off  (r_offy),
        .i_x    (r_x),
        .i_y    (r_y),
        .i_w    (r_w),
        .i_h    (r_h),
        .o_span (span_y)
    );

    apr_box u_box (
        .i_clk    (i_clk),
        .i_span_x (span_x),
        .i_span_y (span_y),
        .o_res    (o_res)
    );

    assign o_valid = r_vld[LAT-1];

`ifndef SYNTH
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##5 o_valid)
        else $error("transfer without result after pipeline latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 5))
        else $error("result strobe without matching transfer");

    a_point_extent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req.operation == OP_POINT |-> ##5
            (o_res.out_w == '0 && o_res.out_h == '0))
        else $error("point result with nonzero extent");
`endif

endmodule
`default_nettype wire

// File: rtl/core/apr_axis.sv
`default_nettype none
module apr_axis
    import apr_pkg::*;
#(
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic signed [COEF_W-1:0]  i_ca,
    input  wire logic signed [COEF_W-1:0]  i_cb,
    input  wire logic signed [COORD_W-1:0] i_off,
    input  wire logic signed [COORD_W-1:0] i_x,
    input  wire logic signed [COORD_W-1:0] i_y,
    input  wire logic        [EXT_W-1:0]   i_w,
    input  wire logic        [EXT_W-1:0]   i_h,
    output t_span                          o_span
);

    localparam logic signed [ACC_W-1:0] HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] ZERO = '0;

    logic signed [PROD_W-1:0] n_p_x, n_p_y, n_p_w, n_p_h;
    logic signed [PROD_W-1:0] r_p_x, r_p_y, r_p_w, r_p_h;
    logic signed [ACC_W-1:0]  n_off, r_off;
    logic signed [ACC_W-1:0]  n_base, n_lo_adj, n_hi_adj;
    logic signed [ACC_W-1:0]  r_base, r_lo_adj, r_hi_adj;
    logic signed [ACC_W-1:0]  n_lo, n_hi, r_lo, r_hi;

    // stage 1: products
    assign n_p_x = i_ca * i_x;
    assign n_p_y = i_cb * i_y;
    assign n_p_w = i_ca * $signed({1'b0, i_w});
    assign n_p_h = i_cb * $signed({1'b0, i_h});
    assign n_off = ACC_W'(i_off) <<< COEF_FRAC_BITS;

    // stage 2: origin corner and per-axis corner offsets
    assign n_base   = ACC_W'(r_p_x) + ACC_W'(r_p_y) + r_off;
    assign n_lo_adj = (r_p_w[PROD_W-1] ? ACC_W'(r_p_w) : ZERO)
                    + (r_p_h[PROD_W-1] ? ACC_W'(r_p_h) : ZERO);
    assign n_hi_adj = (r_p_w[PROD_W-1] ? ZERO : ACC_W'(r_p_w))
                    + (r_p_h[PROD_W-1] ? ZERO : ACC_W'(r_p_h));

    // stage 3: extreme corners plus rounding half; rounding is monotone
    assign n_lo = r_base + r_lo_adj + HALF;
    assign n_hi = r_base + r_hi_adj + HALF;

    always_ff @(posedge i_clk) begin
        r_p_x    <= n_p_x;
        r_p_y    <= n_p_y;
        r_p_w    <= n_p_w;
        r_p_h    <= n_p_h;
        r_off    <= n_off;
        r_base   <= n_base;
        r_lo_adj <= n_lo_adj;
        r_hi_adj <= n_hi_adj;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
    end

    assign o_span.lo = r_lo >>> COEF_FRAC_BITS;
    assign o_span.hi = r_hi >>> COEF_FRAC_BITS;

endmodule
`default_nettype wire

// File: rtl/core/apr_box.sv
`default_nettype none
module apr_box
    import apr_pkg::*;
(
    input  wire logic  i_clk,
    input  t_span      i_span_x,
    input  t_span      i_span_y,
    output t_res       o_res
);

    localparam logic signed [ACC_W-1:0] C_MAX = ACC_W'((2 ** (COORD_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] C_MIN = -C_MAX - 1;
    localparam logic signed [ACC_W-1:0] E_MAX = ACC_W'((2 ** EXT_W) - 1);
    localparam logic signed [ACC_W-1:0] ZERO  = '0;

    function automatic logic [COORD_W:0] sat_coord(input logic signed [ACC_W-1:0] v);
        logic [COORD_W:0] r;
        if (v > C_MAX) begin
            r = {1'b1, C_MAX[COORD_W-1:0]};
        end else if (v < C_MIN) begin
            r = {1'b1, C_MIN[COORD_W-1:0]};
        end else begin
            r = {1'b0, v[COORD_W-1:0]};
        end
        return r;
    endfunction

    function automatic logic [EXT_W:0] sat_ext(input logic signed [ACC_W-1:0] v);
        logic [EXT_W:0] r;
        if (v > E_MAX) begin
            r = {1'b1, E_MAX[EXT_W-1:0]};
        end else if (v < ZERO) begin
            r = {1'b1, {EXT_W{1'b0}}};
        end else begin
            r = {1'b0, v[EXT_W-1:0]};
        end
        return r;
    endfunction

    logic signed [ACC_W-1:0] ext_x, ext_y;
    logic [COORD_W:0]        sx, sy;
    logic [EXT_W:0]          sw, sh;
    t_res                    n_res, r_res;

    assign ext_x = i_span_x.hi - i_span_x.lo;
    assign ext_y = i_span_y.hi - i_span_y.lo;

    always_comb begin
        sx = sat_coord(i_span_x.lo);
        sy = sat_coord(i_span_y.lo);
        sw = sat_ext(ext_x);
        sh = sat_ext(ext_y);
        n_res.out_x   = sx[COORD_W-1:0];
        n_res.out_y   = sy[COORD_W-1:0];
        n_res.out_w   = sw[EXT_W-1:0];
        n_res.out_h   = sh[EXT_W-1:0];
        n_res.clipped = sx[COORD_W] | sy[COORD_W] | sw[EXT_W] | sh[EXT_W];
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule
`default_nettype wire

// File: bench/affine_point_rect_map_test.sv
`timescale 1ns / 100ps
module affine_point_rect_map_test;
    import apr_pkg::*;

    localparam int     COEF_FRAC   = 16;
    localparam longint COORD_MAX   = (longint'(1) <<< 23) - 1;
    localparam longint COORD_MIN   = -(longint'(1) <<< 23);
    localparam longint EXT_MAX     = (longint'(1) <<< 23) - 1;
    localparam longint COEF_ONE    = longint'(1) <<< COEF_FRAC;
    localparam longint ROUND_HALF  = longint'(1) <<< (COEF_FRAC - 1);
    localparam int     QUIET_LIMIT = 1000;

    // indexes past the last register
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    typedef enum int {
        MIX_NEAR_UNIT = 0,
        MIX_FULL      = 1,
        MIX_EXTREME   = 2,
        MIX_ANY       = 3
    } t_coef_mix;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_req              i_req;
    logic              o_valid;
    t_res              o_res;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_idx;
    logic [COEF_W-1:0] i_cfg_data;

    logic signed [COEF_W-1:0] matrix_regs [6];
    t_res pending_boxes [$];
    int   mismatches  = 0;
    int   quiet_cycles = 0;

    affine_point_rect_map dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_req     (i_req),
        .o_valid   (o_valid),
        .o_res     (o_res),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint project(longint ca, longint cb, longint off,
                                       longint x, longint y);
        longint acc;
        acc = ca * x + cb * y + (off <<< COEF_FRAC);
        return (acc + ROUND_HALF) >>> COEF_FRAC;
    endfunction

    function automatic longint saturate(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // a point is a rectangle of zero extent: same box, zero size, no extra clipping
    function automatic t_res transform_item(t_req r);
        longint x0, y0, w, h, cx, cy, px, py;
        longint min_x, max_x, min_y, max_y;
        longint sx, sy, sw, sh;
        t_res   res;
        x0 = longint'(r.pos_x);
        y0 = longint'(r.pos_y);
        w  = (r.operation == OP_RECT) ? longint'(r.extent_w) : 0;
        h  = (r.operation == OP_RECT) ? longint'(r.extent_h) : 0;
        for (int k = 0; k < 4; k++) begin
            cx = x0 + ((k == 1 || k == 2) ? w : 0);
            cy = y0 + ((k >= 2) ? h : 0);
            px = project(matrix_regs[REG_COEF_XX], matrix_regs[REG_COEF_XY],
                         matrix_regs[REG_OFFSET_X], cx, cy);
            py = project(matrix_regs[REG_COEF_YX], matrix_regs[REG_COEF_YY],
                         matrix_regs[REG_OFFSET_Y], cx, cy);
            if (k == 0 || px < min_x) min_x = px;
            if (k == 0 || px > max_x) max_x = px;
            if (k == 0 || py < min_y) min_y = py;
            if (k == 0 || py > max_y) max_y = py;
        end
        sx = saturate(min_x, COORD_MIN, COORD_MAX);
        sy = saturate(min_y, COORD_MIN, COORD_MAX);
        sw = saturate(max_x - min_x, 0, EXT_MAX);
        sh = saturate(max_y - min_y, 0, EXT_MAX);
        res.out_x   = COORD_W'(sx);
        res.out_y   = COORD_W'(sy);
        res.out_w   = EXT_W'(sw);
        res.out_h   = EXT_W'(sh);
        res.clipped = (sx != min_x) || (sy != min_y) ||
                      (sw != max_x - min_x) || (sh != max_y - min_y);
        return res;
    endfunction

    function automatic t_req make_item(logic op, longint x, longint y,
                                       longint w, longint h);
        t_req r;
        r.operation = op;
        r.pos_x     = COORD_W'(x);
        r.pos_y     = COORD_W'(y);
        r.extent_w  = EXT_W'(w);
        r.extent_h  = EXT_W'(h);
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 3))
            0, 1: return COORD_W'(int'($urandom_range(0, 131072)) - 65536);
            2: return COORD_W'($urandom);
            default: begin
                case ($urandom_range(0, 4))
                    0: return COORD_W'(COORD_MIN);
                    1: return COORD_W'(COORD_MAX);
                    2: return '0;
                    3: return '1;
                    default: return COORD_W'(1);
                endcase
            end
        endcase
    endfunction

    function automatic logic [EXT_W-1:0] rand_extent();
        case ($urandom_range(0, 3))
            0, 1: return EXT_W'($urandom_range(0, 16384));
            2: return EXT_W'($urandom);
            default: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return EXT_W'(1);
                    default: return EXT_W'(EXT_MAX);
                endcase
            end
        endcase
    endfunction

    function automatic t_req rand_item();
        return make_item($urandom_range(0, 1) ? OP_RECT : OP_POINT,
                         longint'($signed(rand_coord())), longint'($signed(rand_coord())),
                         rand_extent(), rand_extent());
    endfunction

    function automatic logic [COEF_W-1:0] rand_reg(t_coef_mix mix, int span);
        if (mix == MIX_ANY) mix = t_coef_mix'($urandom_range(0, 2));
        case (mix)
            MIX_NEAR_UNIT: return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
            MIX_FULL: return COEF_W'($urandom);
            default: begin
                case ($urandom_range(0, 4))
                    0: return COEF_W'(COORD_MIN);
                    1: return COEF_W'(COORD_MAX);
                    2: return '0;
                    3: return COEF_W'(COEF_ONE);
                    default: return COEF_W'(-COEF_ONE);
                endcase
            end
        endcase
    endfunction

    task automatic note_failure(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    // leaves i_cfg_we high; the caller lowers it after its last write
    task automatic write_reg(logic [2:0] idx, logic [COEF_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx <= REG_OFFSET_Y) matrix_regs[idx] = data;
    endtask

    task automatic load_matrix(longint xx, longint xy, longint ox,
                               longint yx, longint yy, longint oy);
        write_reg(REG_COEF_XX, COEF_W'(xx));
        write_reg(REG_COEF_XY, COEF_W'(xy));
        write_reg(REG_OFFSET_X, COEF_W'(ox));
        write_reg(REG_COEF_YX, COEF_W'(yx));
        write_reg(REG_COEF_YY, COEF_W'(yy));
        write_reg(REG_OFFSET_Y, COEF_W'(oy));
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_random_matrix(t_coef_mix mix);
        load_matrix($signed(rand_reg(mix, 131072)), $signed(rand_reg(mix, 131072)),
                    $signed(rand_reg(mix, 1 << 20)), $signed(rand_reg(mix, 131072)),
                    $signed(rand_reg(mix, 131072)), $signed(rand_reg(mix, 1 << 20)));
    endtask

    // start stays high on return so the next transfer can follow back to back
    task automatic send_item(t_req r);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_boxes.push_back(transform_item(r));
    endtask

    task automatic pause(int cycles);
        start <= 1'b0;
        i_req <= rand_item();
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_boxes.size() != 0);
    endtask

    task automatic test_identity_after_reset();
        send_item(make_item(OP_POINT, 0, 0, 0, 0));
        send_item(make_item(OP_POINT, COORD_MAX, COORD_MAX, EXT_MAX, EXT_MAX));
        send_item(make_item(OP_POINT, COORD_MIN, COORD_MIN, 0, 0));
        send_item(make_item(OP_RECT, COORD_MIN, COORD_MIN, EXT_MAX, EXT_MAX));
        send_item(make_item(OP_RECT, COORD_MAX, COORD_MAX, EXT_MAX, EXT_MAX));
        send_item(make_item(OP_RECT, 5, -7, 0, 0));
    endtask

    task automatic test_extreme_coefficients();
        drain();
        load_matrix(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_item(make_item(OP_POINT, COORD_MAX, COORD_MAX, 0, 0));
        send_item(make_item(OP_POINT, COORD_MIN, COORD_MIN, 0, 0));
        send_item(make_item(OP_RECT, 0, 0, EXT_MAX, EXT_MAX));
        send_item(make_item(OP_POINT, 1, 1, 0, 0));
        drain();
        load_matrix(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_item(make_item(OP_POINT, COORD_MAX, COORD_MIN, 0, 0));
        send_item(make_item(OP_POINT, COORD_MIN, COORD_MIN, 0, 0));
        send_item(make_item(OP_RECT, COORD_MIN, 0, EXT_MAX, 1));
    endtask

    task automatic test_rotations();
        drain();
        load_matrix(-COEF_ONE, 0, 0, 0, -COEF_ONE, 0);
        send_item(make_item(OP_RECT, 0, 0, 256, 512));
        send_item(make_item(OP_POINT, 256, -256, 0, 0));
        drain();
        load_matrix(0, -COEF_ONE, 1000, COEF_ONE, 0, -1000);
        send_item(make_item(OP_RECT, 100, 200, 300, 50));
    endtask

    task automatic test_rounding_ties();
        drain();
        load_matrix(ROUND_HALF, 0, 0, 0, ROUND_HALF, 0);
        send_item(make_item(OP_POINT, 1, -1, 0, 0));
        send_item(make_item(OP_POINT, -3, 3, 0, 0));
        send_item(make_item(OP_RECT, -1, -1, 2, 2));
    endtask

    task automatic test_ignored_register_index();
        drain();
        write_reg(REG_COEF_XX, COEF_W'(COEF_ONE));
        write_reg(REG_COEF_XY, '0);
        write_reg(REG_OFFSET_X, '0);
        write_reg(REG_COEF_YX, '0);
        write_reg(REG_COEF_YY, COEF_W'(COEF_ONE));
        write_reg(REG_OFFSET_Y, '0);
        write_reg(REG_SPARE_6, COEF_W'($urandom));
        write_reg(REG_SPARE_7, '1);
        i_cfg_we <= 1'b0;
        send_item(make_item(OP_POINT, 256, -512, 0, 0));
        send_item(make_item(OP_RECT, -300, 40, 77, 9));
    endtask

    task automatic test_random_matrices();
        t_coef_mix mix;
        int        pick;
        bit        gappy;
        for (int phase = 0; phase < 20; phase++) begin
            pick  = $urandom_range(0, 5);
            mix   = (pick < 3) ? MIX_NEAR_UNIT : t_coef_mix'(pick - 2);
            gappy = (phase % 4 != 0);
            drain();
            load_random_matrix(mix);
            for (int n = 0; n < 50; n++) begin
                send_item(rand_item());
                if ($urandom_range(0, 99) == 0) drain();
                else if (gappy && $urandom_range(0, 3) == 0) pause($urandom_range(1, 5));
            end
        end
    endtask

    task automatic test_streaming_no_gaps();
        drain();
        load_random_matrix(MIX_NEAR_UNIT);
        for (int n = 0; n < 150; n++) send_item(rand_item());
    endtask

    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && o_valid) begin
            if (pending_boxes.size() == 0) begin
                note_failure($sformatf("unexpected result x=%0d y=%0d w=%0d h=%0d clip=%0b",
                                       o_res.out_x, o_res.out_y, o_res.out_w,
                                       o_res.out_h, o_res.clipped));
            end else begin
                want = pending_boxes.pop_front();
                if (o_res.out_x !== want.out_x || o_res.out_y !== want.out_y ||
                    o_res.out_w !== want.out_w || o_res.out_h !== want.out_h ||
                    o_res.clipped !== want.clipped) begin
                    note_failure($sformatf(
                        "mismatch: expected x=%0d y=%0d w=%0d h=%0d clip=%0b, got x=%0d y=%0d w=%0d h=%0d clip=%0b",
                        want.out_x, want.out_y, want.out_w, want.out_h, want.clipped,
                        o_res.out_x, o_res.out_y, o_res.out_w, o_res.out_h,
                        o_res.clipped));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("affine_point_rect_map test failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_req      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_COEF_XX;
        i_cfg_data <= '0;
        matrix_regs[REG_COEF_XX]  = COEF_W'(COEF_ONE);
        matrix_regs[REG_COEF_XY]  = '0;
        matrix_regs[REG_OFFSET_X] = '0;
        matrix_regs[REG_COEF_YX]  = '0;
        matrix_regs[REG_COEF_YY]  = COEF_W'(COEF_ONE);
        matrix_regs[REG_OFFSET_Y] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_identity_after_reset();
        test_extreme_coefficients();
        test_rotations();
        test_rounding_ties();
        test_ignored_register_index();
        test_random_matrices();
        test_streaming_no_gaps();

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_boxes.size() == 0) begin
            $display("affine_point_rect_map test passed");
        end else begin
            $display("affine_point_rect_map test failed");
        end
        $finish;
    end

endmodule
